// File: design/rrts_pkg.sv
`timescale 1ns / 1ps
package rrts_pkg;
    localparam int NTHR = 16;
    localparam int TW = 4;
    localparam int CW = 5;

    typedef enum logic [2:0] {
        CMD_SPAWN = 3'd0,
        CMD_TERM = 3'd1,
        CMD_BLOCK = 3'd2,
        CMD_RESUME = 3'd3,
        CMD_SYNC = 3'd4,
        CMD_TICK = 3'd5,
        CMD_QUERY = 3'd6,
        CMD_BAD = 3'd7
    } cmd_t;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    localparam logic [1:0] RS_OK = 2'd0;
    localparam logic [1:0] RS_ERR = 2'd1;
    localparam logic [1:0] RS_HALT = 2'd2;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_REMOVE,
        OP_SHIFT,
        OP_PUSH_TID,
        OP_PUSH_HEAD,
        OP_SET_ST,
        OP_WAKE_SCAN,
        OP_CLR_COL,
        OP_FREE,
        OP_NEXT_RUN,
        OP_TICK_ONE,
        OP_SPAWN,
        OP_ADD_WAITER
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic [1:0] st_val;
        logic use_head;
        logic [TW-1:0] scan;
        logic set_halt;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [TW-1:0] tid;
        logic [TW-1:0] head;
        logic [1:0] tid_st;
        logic valid;
        logic halted;
        logic [CW-1:0] count;
        logic found_ok;
        logic rm_hit;
    } dp_stat_t;
endpackage

// File: design/round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// Every command is latched, decoded and its result registered. A block, a tick or a sync
// may first close up the queue one entry per cycle; a terminate does so too and then
// scans one waiter-mask entry per cycle over 16 ids, twice. One command at a time; the
// next is accepted once the result sits in the output register, and its own result
// waits while that register is full.
// Reset: thread 0 running alone with one quantum, total one, not halted.
module round_robin_thread_scheduler
    import rrts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // cmd[2:0], thread_id[6:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata   // status[1:0], value[33:2], running_id[37:34],
                                  // quantum total[69:38], zero pad
);
    dp_cmd_t dc;
    dp_stat_t st;
    logic busy, done, rv_q, rv_sp, in_fire, out_free;
    logic [1:0] rs;
    logic [31:0] qt, tot;
    logic [TW-1:0] nid, hid;
    logic [31:0] val;
    logic [71:0] out_reg;
    logic ov_reg;

    assign s_tready = !busy;
    assign in_fire = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata = out_reg;

    rrts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .st(st), .dc(dc), .busy(busy), .done(done), .res_status(rs),
        .res_val_q(rv_q), .res_val_spawn(rv_sp)
    );

    rrts_dp u_dp (
        .clk(clk), .rst_n(rst_n), .dc(dc), .in_cmd(s_tdata[2:0]),
        .in_tid(s_tdata[6:3]), .st(st), .quanta_tid(qt), .new_id(nid),
        .head_id(hid), .total(tot)
    );

    // The spawned id is taken before the spawn lands, so it is held here.
    logic [TW-1:0] sid_reg;
    always_ff @(posedge clk)
    begin
        if (dc.op == OP_SPAWN)
            sid_reg <= nid;
    end

    assign val = rv_q ? qt : (rv_sp ? 32'(sid_reg) : 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (done)
            ov_reg <= 1'b1;
        else if (m_tready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_reg <= {2'b00, tot, hid, val, rs};
    end
endmodule

// File: design/rrts_ctrl.sv
`timescale 1ns / 1ps
module rrts_ctrl
    import rrts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     out_free,
    input  dp_stat_t st,
    output dp_cmd_t  dc,
    output logic     busy,
    output logic     done,
    output logic [1:0] res_status,
    output logic     res_val_q,
    output logic     res_val_spawn
);
    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_SHIFT, S_WAKE, S_CLR, S_FIN, S_OUT
    } state_t;

    typedef enum logic [1:0] { K_TICK, K_BLOCK, K_TERM, K_OTHER } kind_t;

    state_t state_reg, state_next;
    kind_t kind_reg, kind_next;
    logic [TW-1:0] scan_reg, scan_next;
    logic [1:0] rs_reg, rs_next;
    logic q_reg, q_next, sp_reg, sp_next;
    logic tgt_head_reg, tgt_head_next;
    logic endrun_reg, endrun_next;

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_OUT && out_free;
    assign res_status = rs_reg;
    assign res_val_q = q_reg;
    assign res_val_spawn = sp_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        scan_next = scan_reg;
        rs_next = rs_reg;
        q_next = q_reg;
        sp_next = sp_reg;
        tgt_head_next = tgt_head_reg;
        endrun_next = endrun_reg;
        dc = '0;
        dc.op = OP_NONE;
        dc.scan = scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    dc.op = OP_LATCH;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                rs_next = RS_OK;
                q_next = 1'b0;
                sp_next = 1'b0;
                scan_next = '0;
                endrun_next = 1'b0;
                tgt_head_next = 1'b0;
                state_next = S_OUT;
                if (st.halted)
                    rs_next = RS_HALT;
                else
                begin
                    unique case (cmd_t'(st.cmd))
                        CMD_SPAWN:
                        begin
                            if (!st.found_ok)
                                rs_next = RS_ERR;
                            else
                            begin
                                dc.op = OP_SPAWN;
                                sp_next = 1'b1;
                            end
                        end
                        CMD_TERM:
                        begin
                            if (!st.valid)
                                rs_next = RS_ERR;
                            else if (st.tid == '0)
                            begin
                                dc.set_halt = 1'b1;
                                rs_next = RS_HALT;
                            end
                            else if (st.tid == st.head)
                            begin
                                kind_next = K_TERM;
                                tgt_head_next = 1'b1;
                                endrun_next = 1'b1;
                                dc.op = OP_REMOVE;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                kind_next = K_TERM;
                                dc.op = OP_REMOVE;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_BLOCK:
                        begin
                            if (!st.valid || st.tid == '0)
                                rs_next = RS_ERR;
                            else if (st.tid_st != ST_BLOCKED)
                            begin
                                kind_next = K_BLOCK;
                                endrun_next = st.tid == st.head;
                                tgt_head_next = st.tid == st.head;
                                dc.op = OP_REMOVE;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_RESUME:
                        begin
                            if (!st.valid || st.tid == '0)
                                rs_next = RS_ERR;
                            else if (st.tid_st == ST_BLOCKED)
                                dc.op = OP_PUSH_TID;
                        end
                        CMD_SYNC:
                        begin
                            if (!st.valid || st.tid == '0 || st.tid == st.head
                                || st.head == '0)
                                rs_next = RS_ERR;
                            else
                            begin
                                dc.op = OP_ADD_WAITER;
                                kind_next = K_BLOCK;
                                endrun_next = 1'b1;
                                tgt_head_next = 1'b1;
                                scan_next = TW'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (st.count <= CW'(1))
                                dc.op = OP_TICK_ONE;
                            else
                            begin
                                kind_next = K_TICK;
                                endrun_next = 1'b1;
                                tgt_head_next = 1'b1;
                                scan_next = TW'(1);
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (!st.valid)
                                rs_next = RS_ERR;
                            else
                                q_next = 1'b1;
                        end
                        default: rs_next = RS_ERR;
                    endcase
                end
            end
            S_SHIFT:
            begin
                // A nonzero scan marks a head removal still to be issued. After
                // that, one queue entry moves down per cycle until the gap closes.
                if (scan_reg != '0)
                begin
                    dc.op = OP_REMOVE;
                    scan_next = '0;
                end
                else if (st.rm_hit)
                    dc.op = OP_SHIFT;
                else
                begin
                    unique case (kind_reg)
                        K_TICK:
                        begin
                            dc.op = OP_PUSH_HEAD;
                            state_next = S_FIN;
                        end
                        K_BLOCK:
                        begin
                            dc.op = OP_SET_ST;
                            dc.st_val = ST_BLOCKED;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            scan_next = '0;
                            state_next = S_WAKE;
                        end
                    endcase
                end
            end
            S_WAKE:
            begin
                dc.op = OP_WAKE_SCAN;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == TW'(NTHR - 1))
                begin
                    scan_next = '0;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                dc.op = OP_CLR_COL;
                scan_next = scan_reg + 1'b1;
                if (scan_reg == TW'(NTHR - 1))
                begin
                    dc.op = OP_FREE;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (endrun_reg)
                    dc.op = OP_NEXT_RUN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // The decode cycle already picks its removal target.
        dc.use_head = tgt_head_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg <= K_OTHER;
            scan_reg <= '0;
            rs_reg <= RS_OK;
            q_reg <= 1'b0;
            sp_reg <= 1'b0;
            tgt_head_reg <= 1'b0;
            endrun_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            scan_reg <= scan_next;
            rs_reg <= rs_next;
            q_reg <= q_next;
            sp_reg <= sp_next;
            tgt_head_reg <= tgt_head_next;
            endrun_reg <= endrun_next;
        end
    end
endmodule

// File: design/rrts_dp.sv
`timescale 1ns / 1ps
module rrts_dp
    import rrts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     dc,
    input  logic [2:0]  in_cmd,
    input  logic [TW-1:0] in_tid,
    output dp_stat_t    st,
    output logic [31:0] quanta_tid,
    output logic [TW-1:0] new_id,
    output logic [TW-1:0] head_id,
    output logic [31:0] total
);
    logic [TW-1:0] q_reg [NTHR];
    logic [CW-1:0] cnt_reg;
    logic [1:0] ts_reg [NTHR];
    logic [31:0] qa_reg [NTHR];
    logic [NTHR-1:0] sw_reg [NTHR];
    logic [31:0] tot_reg;
    logic halt_reg;
    logic [2:0] cmd_reg;
    logic [TW-1:0] tid_reg, tgt_reg, pos_reg;
    logic hit_reg;

    logic [TW-1:0] head, tgt, free_id, match_pos;
    logic found, match;

    assign head = q_reg[0];
    assign tgt = dc.use_head ? head : tid_reg;

    always_comb
    begin
        free_id = '0;
        found = 1'b0;
        for (int i = NTHR - 1; i >= 1; i--)
        begin
            if (ts_reg[i] == ST_FREE)
            begin
                free_id = TW'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        match_pos = '0;
        match = 1'b0;
        for (int i = NTHR - 1; i >= 0; i--)
        begin
            if (CW'(i) < cnt_reg && q_reg[i] == tgt)
            begin
                match_pos = TW'(i);
                match = 1'b1;
            end
        end
    end

    always_comb
    begin
        st.cmd = cmd_reg;
        st.tid = tid_reg;
        st.head = head;
        st.tid_st = ts_reg[tid_reg];
        st.valid = ts_reg[tid_reg] != ST_FREE;
        st.halted = halt_reg;
        st.count = cnt_reg;
        st.found_ok = found;
        st.rm_hit = hit_reg;
    end

    assign quanta_tid = qa_reg[tid_reg];
    assign new_id = free_id;
    assign head_id = head;
    assign total = tot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NTHR; i++)
            begin
                q_reg[i] <= '0;
                ts_reg[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
                qa_reg[i] <= (i == 0) ? 32'd1 : 32'd0;
                sw_reg[i] <= '0;
            end
            cnt_reg <= CW'(1);
            tot_reg <= 32'd1;
            halt_reg <= 1'b0;
            cmd_reg <= '0;
            tid_reg <= '0;
            tgt_reg <= '0;
            pos_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (dc.set_halt)
                halt_reg <= 1'b1;
            unique case (dc.op)
                OP_LATCH:
                begin
                    cmd_reg <= in_cmd;
                    tid_reg <= in_tid;
                end
                OP_REMOVE:
                begin
                    tgt_reg <= tgt;
                    pos_reg <= match_pos;
                    hit_reg <= match;
                end
                OP_SHIFT:
                begin
                    if (CW'(pos_reg) + CW'(1) < cnt_reg)
                    begin
                        q_reg[pos_reg] <= q_reg[pos_reg + 1'b1];
                        pos_reg <= pos_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        hit_reg <= 1'b0;
                    end
                end
                OP_PUSH_TID:
                begin
                    ts_reg[tid_reg] <= ST_READY;
                    if (cnt_reg < CW'(NTHR))
                    begin
                        q_reg[cnt_reg[TW-1:0]] <= tid_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                OP_PUSH_HEAD:
                begin
                    ts_reg[tgt_reg] <= ST_READY;
                    if (cnt_reg < CW'(NTHR))
                    begin
                        q_reg[cnt_reg[TW-1:0]] <= tgt_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                OP_SET_ST: ts_reg[tgt_reg] <= dc.st_val;
                OP_WAKE_SCAN:
                begin
                    if (sw_reg[tgt_reg][dc.scan])
                    begin
                        sw_reg[tgt_reg][dc.scan] <= 1'b0;
                        if (ts_reg[dc.scan] == ST_BLOCKED)
                        begin
                            ts_reg[dc.scan] <= ST_READY;
                            if (cnt_reg < CW'(NTHR))
                            begin
                                q_reg[cnt_reg[TW-1:0]] <= dc.scan;
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end
                    end
                end
                OP_CLR_COL: sw_reg[dc.scan][tgt_reg] <= 1'b0;
                OP_FREE:
                begin
                    sw_reg[dc.scan][tgt_reg] <= 1'b0;
                    ts_reg[tgt_reg] <= ST_FREE;
                    qa_reg[tgt_reg] <= '0;
                end
                OP_NEXT_RUN:
                begin
                    if (cnt_reg != '0)
                    begin
                        ts_reg[head] <= ST_RUNNING;
                        if (qa_reg[head] != '1)
                            qa_reg[head] <= qa_reg[head] + 1'b1;
                        if (tot_reg != '1)
                            tot_reg <= tot_reg + 1'b1;
                    end
                end
                OP_TICK_ONE:
                begin
                    if (qa_reg[head] != '1)
                        qa_reg[head] <= qa_reg[head] + 1'b1;
                    if (tot_reg != '1)
                        tot_reg <= tot_reg + 1'b1;
                end
                OP_SPAWN:
                begin
                    ts_reg[free_id] <= ST_READY;
                    qa_reg[free_id] <= '0;
                    sw_reg[free_id] <= '0;
                    if (cnt_reg < CW'(NTHR))
                    begin
                        q_reg[cnt_reg[TW-1:0]] <= free_id;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                OP_ADD_WAITER: sw_reg[tid_reg][head] <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

// File: test/tb_round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
module tb_round_robin_thread_scheduler;
    import rrts_pkg::*;

    // Packed from the top bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [31:0] quanta_sum;
        logic [3:0]  running_id;
        logic [31:0] value;
        logic [1:0]  status;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    round_robin_thread_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Scheduler state as the testbench sees it.
    logic [3:0]  run_queue [NTHR];
    int          run_len;
    logic [1:0]  tstate [NTHR];
    logic [31:0] tquanta [NTHR];
    logic [NTHR-1:0] waiters [NTHR];
    logic [31:0] total_q;
    bit          is_halted;

    sched_result_t expected_results[$];
    int errors;
    int items_sent;
    int results_seen;
    int idle_cycles;
    int halt_seen;
    int spawn_ok;
    int sync_ok;
    int burst_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < NTHR; i++)
        begin
            run_queue[i] = '0;
            tstate[i] = ST_FREE;
            tquanta[i] = '0;
            waiters[i] = '0;
        end
        run_len = 1;
        tstate[0] = ST_RUNNING;
        tquanta[0] = 32'd1;
        total_q = 32'd1;
        is_halted = 1'b0;
    endfunction

    function automatic void q_push(logic [3:0] id);
        if (run_len < NTHR)
        begin
            run_queue[run_len] = id;
            run_len++;
        end
    endfunction

    function automatic void q_remove_at(int pos);
        if (pos >= run_len)
            return;
        for (int i = pos; i + 1 < run_len; i++)
            run_queue[i] = run_queue[i + 1];
        run_len--;
    endfunction

    function automatic void q_remove_id(logic [3:0] id);
        for (int i = 0; i < run_len; i++)
            if (run_queue[i] == id)
            begin
                q_remove_at(i);
                return;
            end
    endfunction

    function automatic void wake(int id);
        if (tstate[id] == ST_BLOCKED)
        begin
            tstate[id] = ST_READY;
            q_push(id[3:0]);
        end
    endfunction

    function automatic void free_thread(int id);
        for (int w = 0; w < NTHR; w++)
            if (waiters[id][w])
            begin
                waiters[id][w] = 1'b0;
                wake(w);
            end
        for (int w = 0; w < NTHR; w++)
            waiters[w][id] = 1'b0;
        tstate[id] = ST_FREE;
        tquanta[id] = '0;
    endfunction

    // kind: 0 tick, 1 block, 2 terminate
    function automatic void rotate(int kind);
        int hd;
        int nx;
        hd = run_queue[0];
        if (run_len <= 1 && kind == 0)
        begin
            tquanta[hd] = sat_inc(tquanta[hd]);
            total_q = sat_inc(total_q);
            return;
        end
        q_remove_at(0);
        if (kind == 0)
        begin
            tstate[hd] = ST_READY;
            q_push(hd[3:0]);
        end
        else if (kind == 1)
            tstate[hd] = ST_BLOCKED;
        else
            free_thread(hd);
        if (run_len == 0)
            return;
        nx = run_queue[0];
        tstate[nx] = ST_RUNNING;
        tquanta[nx] = sat_inc(tquanta[nx]);
        total_q = sat_inc(total_q);
    endfunction

    function automatic sched_result_t schedule_cmd(cmd_t c, logic [3:0] tid);
        sched_result_t r;
        bit ok;
        int hd;
        int found;
        r = '0;
        if (is_halted)
            r.status = RS_HALT;
        else
        begin
            ok = tstate[tid] != ST_FREE;
            hd = run_queue[0];
            case (c)
                CMD_SPAWN:
                begin
                    found = 0;
                    for (int i = 1; i < NTHR; i++)
                        if (found == 0 && tstate[i] == ST_FREE)
                            found = i;
                    if (found == 0)
                        r.status = RS_ERR;
                    else
                    begin
                        tstate[found] = ST_READY;
                        tquanta[found] = '0;
                        waiters[found] = '0;
                        q_push(found[3:0]);
                        r.value = found;
                        spawn_ok++;
                    end
                end
                CMD_TERM:
                    if (!ok)
                        r.status = RS_ERR;
                    else if (tid == 0)
                    begin
                        is_halted = 1'b1;
                        r.status = RS_HALT;
                    end
                    else if (tid == hd)
                        rotate(2);
                    else
                    begin
                        if (tstate[tid] != ST_BLOCKED)
                            q_remove_id(tid);
                        free_thread(tid);
                    end
                CMD_BLOCK:
                    if (!ok || tid == 0)
                        r.status = RS_ERR;
                    else if (tstate[tid] == ST_BLOCKED)
                        ;
                    else if (tid == hd)
                        rotate(1);
                    else
                    begin
                        q_remove_id(tid);
                        tstate[tid] = ST_BLOCKED;
                    end
                CMD_RESUME:
                    if (!ok || tid == 0)
                        r.status = RS_ERR;
                    else
                        wake(tid);
                CMD_SYNC:
                    if (!ok || tid == 0 || tid == hd || hd == 0)
                        r.status = RS_ERR;
                    else
                    begin
                        waiters[tid][hd] = 1'b1;
                        rotate(1);
                        sync_ok++;
                    end
                CMD_TICK:
                    rotate(0);
                CMD_QUERY:
                    if (!ok)
                        r.status = RS_ERR;
                    else
                        r.value = tquanta[tid];
                default:
                    r.status = RS_ERR;
            endcase
        end
        r.running_id = run_queue[0];
        r.quanta_sum = total_q;
        return r;
    endfunction

    task automatic send_cmd(cmd_t c, logic [3:0] tid);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 4)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = {1'b0, tid, c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results = {expected_results, schedule_cmd(c, tid)};
        items_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Receiver stall pattern, independent of the sender.
    always @(negedge clk)
        if (rst_n)
            m_tready <= ($urandom_range(0, 15) < 11) || (($urandom & 32'h3F) == 0);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sched_result_t got;
            sched_result_t exp_r;
            got = m_tdata[69:0];
            results_seen++;
            if (m_tdata[71:70] != 2'b00)
            begin
                $error("pad: expected 0 actual %0h", m_tdata[71:70]);
                errors++;
            end
            if (expected_results.size() == 0)
            begin
                $error("result with no expectation: %0h", m_tdata);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.status != exp_r.status)
                begin
                    $error("status: expected %0d actual %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.value != exp_r.value)
                begin
                    $error("value: expected %0d actual %0d", exp_r.value, got.value);
                    errors++;
                end
                if (got.running_id != exp_r.running_id)
                begin
                    $error("running_id: expected %0d actual %0d",
                           exp_r.running_id, got.running_id);
                    errors++;
                end
                if (got.quanta_sum != exp_r.quanta_sum)
                begin
                    $error("quanta_sum: expected %0d actual %0d",
                           exp_r.quanta_sum, got.quanta_sum);
                    errors++;
                end
                if (exp_r.status == RS_HALT)
                    halt_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 5000)
        begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_directed();
        send_cmd(CMD_TICK, 4'd0);
        send_cmd(CMD_QUERY, 4'd0);
        send_cmd(CMD_QUERY, 4'd15);
        send_cmd(CMD_BLOCK, 4'd0);
        send_cmd(CMD_RESUME, 4'd0);
        send_cmd(CMD_SYNC, 4'd0);
        send_cmd(CMD_BAD, 4'd9);
        send_cmd(CMD_SPAWN, 4'd0);
        send_cmd(CMD_SPAWN, 4'd15);
        send_cmd(CMD_TICK, 4'd0);
        send_cmd(CMD_SYNC, 4'd2);
        send_cmd(CMD_SYNC, 4'd1);
        send_cmd(CMD_BLOCK, 4'd2);
        send_cmd(CMD_BLOCK, 4'd2);
        send_cmd(CMD_RESUME, 4'd2);
        send_cmd(CMD_RESUME, 4'd2);
        send_cmd(CMD_TICK, 4'd0);
        send_cmd(CMD_TERM, 4'd2);
        send_cmd(CMD_TERM, 4'd2);
        send_cmd(CMD_QUERY, 4'd1);
        send_cmd(CMD_TERM, 4'd5);
    endtask

    task automatic test_spawn_full();
        for (int i = 0; i < 17; i++)
            send_cmd(CMD_SPAWN, 4'($urandom));
        send_cmd(CMD_TICK, 4'd0);
        send_cmd(CMD_TERM, 4'd7);
        send_cmd(CMD_SPAWN, 4'd0);
    endtask

    // Mostly targets live ids so that sync chains and terminates with waiters occur.
    task automatic test_random(int n);
        cmd_t c;
        logic [3:0] tid;
        int live[$];
        for (int k = 0; k < n; k++)
        begin
            live.delete();
            for (int i = 0; i < NTHR; i++)
                if (tstate[i] != ST_FREE)
                    live = {live, i};
            case ($urandom_range(0, 19))
                0, 1, 2:    c = CMD_SPAWN;
                3, 4:       c = CMD_TERM;
                5, 6:       c = CMD_BLOCK;
                7, 8, 9:    c = CMD_RESUME;
                10, 11, 12: c = CMD_SYNC;
                13, 14, 15: c = CMD_TICK;
                16, 17:     c = CMD_QUERY;
                default:    c = cmd_t'($urandom_range(0, 7));
            endcase
            if ($urandom_range(0, 9) < 8 && live.size() > 0)
                tid = 4'(live[$urandom_range(0, live.size() - 1)]);
            else
                tid = 4'($urandom);
            // Keep thread 0 alive for most of the run.
            if (c == CMD_TERM && tid == 0 && $urandom_range(0, 3) != 0)
                tid = 4'($urandom_range(1, 15));
            if (c == CMD_TERM && tid == 0 && k < n - 20)
                tid = 4'd1;
            send_cmd(c, tid);
            if (k == n / 2)
                drain();
        end
    endtask

    task automatic test_halt();
        send_cmd(CMD_TERM, 4'd0);
        send_cmd(CMD_SPAWN, 4'd0);
        send_cmd(CMD_TICK, 4'd0);
        send_cmd(CMD_QUERY, 4'd0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        halt_seen = 0;
        spawn_ok = 0;
        sync_ok = 0;
        burst_left = 0;
        sched_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_spawn_full();
        test_random(400);
        test_halt();

        drain();
        repeat (60) @(posedge clk);
        $display("Sent %0d commands and checked %0d results.", items_sent, results_seen);
        $display("Successful spawns %0d, syncs %0d, halted answers %0d.",
                 spawn_ok, sync_ok, halt_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
